/* rtl/core/tism_pkg.sv */
package tism_pkg;

   localparam int SIDE_MAX     = 64;
   localparam int ROW_W        = $clog2(SIDE_MAX);
   localparam int SIDE_W       = $clog2(SIDE_MAX + 1);
   localparam int N_W          = 2 * SIDE_W;
   localparam int STEP_W       = $clog2(ROW_W + 1);
   localparam int DIV_W        = SIDE_W + ROW_W;
   localparam int SITE_W       = 12;
   localparam int DRAW_W       = 16;
   localparam int SIDE_FIELD_W = 7;
   localparam int MAG_W        = 14;
   localparam int NSUM_W       = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SIDE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_K2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_K4 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_K6 = 2'd3;

   typedef struct packed {
      logic             done;
      logic [ROW_W-1:0] quot;
      logic [ROW_W-1:0] rem;
   } div_status_type;

endpackage

/* rtl/core/tism_ram.sv */
module tism_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tism_div.sv */
module tism_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tism_pkg::SITE_W-1:0]    dividend,
   input  logic [tism_pkg::SIDE_W-1:0]    divisor,
   output tism_pkg::div_status_type       status
);

   import tism_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [ROW_W-1:0]  quot_ff, quot_in;
   logic [DIV_W-1:0]  shifted;

   assign shifted = DIV_W'(divisor) << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(ROW_W - 1);
         rem_in  = DIV_W'(dividend);
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in           = rem_ff - shifted;
            quot_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.quot = quot_ff;
   assign status.rem  = rem_ff[ROW_W-1:0];

endmodule

/* rtl/core/triangular_ising_metropolis_step.sv */
// Valid site: a one-bit-per-cycle row/column split, then three row reads and a
// write-back on the simple dual-port row memory; the result is registered in the
// evaluate state, and the next beat can be taken in the cycle after it is loaded.
// Out-of-range site: skips the split and row reads and goes straight to evaluate.
// Synchronous reset: side 64, thresholds 0, all spins up via cleared row valid bits,
// magnetization side squared. A side write does the same, thresholds apart.
module triangular_ising_metropolis_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tism_pkg::SITE_W-1:0]         req_site,
   input  logic [tism_pkg::DRAW_W-1:0]         req_random_draw,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_flipped,
   output logic                                rsp_spin_after,
   output logic signed [tism_pkg::NSUM_W-1:0]  rsp_neighbour_sum,
   output logic signed [tism_pkg::MAG_W-1:0]   rsp_magnetization,
   output logic                                rsp_bad_site,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tism_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tism_pkg::CSR_DATA_W-1:0]     csr_data
);

   import tism_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_RD0  = 3'd2;
   localparam logic [2:0] S_RD1  = 3'd3;
   localparam logic [2:0] S_RD2  = 3'd4;
   localparam logic [2:0] S_RD3  = 3'd5;
   localparam logic [2:0] S_EVAL = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [N_W-1:0]      cells_ff;
   logic [DRAW_W-1:0]   acc_k2_ff, acc_k4_ff, acc_k6_ff;
   logic [MAG_W-1:0]    total_ff;
   logic [SIDE_MAX-1:0] row_valid_ff;

   logic [DRAW_W-1:0]   draw_ff;
   logic                bad_ff;
   logic [ROW_W-1:0]    r_ff, c_ff, rl_ff, rd_ff, cl_ff, cr_ff;
   logic [SIDE_MAX-1:0] up_row_ff, mid_row_ff, down_row_ff;
   logic [ROW_W-1:0]    rd_addr_ff;

   logic                rsp_valid_ff;
   logic                rsp_flipped_ff, rsp_spin_after_ff, rsp_bad_site_ff;
   logic [NSUM_W-1:0]   rsp_nsum_ff;
   logic [MAG_W-1:0]    rsp_mag_ff;

   logic                accept, out_free, div_start, side_wr;
   div_status_type      div_status;
   logic [ROW_W-1:0]    sm1, q, cm, rd_addr;
   logic [SIDE_MAX-1:0] rd_row;
   logic [SIDE_MAX-1:0] rd_row_masked;
   logic [SIDE_W-1:0]   side_sat;
   logic                ram_we;
   logic [SIDE_MAX-1:0] wr_row;

   logic                me;
   logic [2:0]          cnt;
   logic [NSUM_W-1:0]   nsum, kval;
   logic                doflip;
   logic [MAG_W-1:0]    total_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign side_wr   = csr_valid && csr_ready && (csr_index == CSR_SIDE);
   assign div_start = accept && (32'(req_site) < 32'(cells_ff));

   always_comb begin
      if (32'(csr_data[SIDE_FIELD_W-1:0]) < 2) begin
         side_sat = SIDE_W'(2);
      end else if (32'(csr_data[SIDE_FIELD_W-1:0]) > SIDE_MAX) begin
         side_sat = SIDE_W'(SIDE_MAX);
      end else begin
         side_sat = SIDE_W'(csr_data[SIDE_FIELD_W-1:0]);
      end
   end

   tism_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_site),
      .divisor  (side_ff),
      .status   (div_status)
   );

   assign sm1 = ROW_W'(side_ff - 1'b1);
   assign q   = div_status.quot;
   assign cm  = div_status.rem;

   always_comb begin
      unique case (state_ff)
         S_RD0:   rd_addr = rl_ff;
         S_RD1:   rd_addr = r_ff;
         default: rd_addr = rd_ff;
      endcase
   end

   tism_ram #(
      .WIDTH (SIDE_MAX),
      .DEPTH (SIDE_MAX)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (r_ff),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   assign rd_row_masked = rd_row & {SIDE_MAX{row_valid_ff[rd_addr_ff]}};

   assign me  = mid_row_ff[c_ff];
   assign cnt = 3'(mid_row_ff[cl_ff]) + 3'(mid_row_ff[cr_ff]) + 3'(up_row_ff[c_ff])
              + 3'(down_row_ff[c_ff]) + 3'(up_row_ff[cl_ff]) + 3'(down_row_ff[cr_ff]);
   assign nsum = NSUM_W'(6) - {cnt, 1'b0};
   assign kval = me ? (NSUM_W'(0) - nsum) : nsum;

   always_comb begin
      if ($signed(kval) <= $signed(NSUM_W'(0))) begin
         doflip = 1'b1;
      end else if (kval == NSUM_W'(2)) begin
         doflip = draw_ff < acc_k2_ff;
      end else if (kval == NSUM_W'(4)) begin
         doflip = draw_ff < acc_k4_ff;
      end else begin
         doflip = draw_ff < acc_k6_ff;
      end
   end

   assign total_next = me ? (total_ff + MAG_W'(2)) : (total_ff - MAG_W'(2));
   assign wr_row     = mid_row_ff ^ (SIDE_MAX'(1) << c_ff);
   assign ram_we     = (state_ff == S_EVAL) && out_free && !bad_ff && doflip;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = div_start ? S_DIV : S_EVAL;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_RD0;
            end
         end
         S_RD0: state_in = S_RD1;
         S_RD1: state_in = S_RD2;
         S_RD2: state_in = S_RD3;
         S_RD3: state_in = S_EVAL;
         S_EVAL: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         side_ff      <= SIDE_W'(SIDE_MAX);
         cells_ff     <= N_W'(SIDE_MAX * SIDE_MAX);
         total_ff     <= MAG_W'(SIDE_MAX * SIDE_MAX);
         acc_k2_ff    <= '0;
         acc_k4_ff    <= '0;
         acc_k6_ff    <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SIDE: begin
                  side_ff      <= side_sat;
                  cells_ff     <= N_W'(side_sat * side_sat);
                  total_ff     <= MAG_W'(side_sat * side_sat);
                  row_valid_ff <= '0;
               end
               CSR_ACCEPT_K2: acc_k2_ff <= csr_data[DRAW_W-1:0];
               CSR_ACCEPT_K4: acc_k4_ff <= csr_data[DRAW_W-1:0];
               CSR_ACCEPT_K6: acc_k6_ff <= csr_data[DRAW_W-1:0];
               default: ;
            endcase
         end
         if ((state_ff == S_EVAL) && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (ram_we) begin
               total_ff            <= total_next;
               row_valid_ff[r_ff]  <= 1'b1;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      if (accept) begin
         draw_ff <= req_random_draw;
         bad_ff  <= !div_start;
      end
      if ((state_ff == S_DIV) && div_status.done) begin
         r_ff  <= q;
         c_ff  <= cm;
         rl_ff <= (q == '0) ? sm1 : q - 1'b1;
         rd_ff <= (q == sm1) ? '0 : q + 1'b1;
         cl_ff <= (cm == '0) ? sm1 : cm - 1'b1;
         cr_ff <= (cm == sm1) ? '0 : cm + 1'b1;
      end
      if (state_ff == S_RD1) begin
         up_row_ff <= rd_row_masked;
      end
      if (state_ff == S_RD2) begin
         mid_row_ff <= rd_row_masked;
      end
      if (state_ff == S_RD3) begin
         down_row_ff <= rd_row_masked;
      end
      if ((state_ff == S_EVAL) && out_free) begin
         rsp_bad_site_ff <= bad_ff;
         if (bad_ff) begin
            rsp_flipped_ff    <= 1'b0;
            rsp_spin_after_ff <= 1'b0;
            rsp_nsum_ff       <= '0;
            rsp_mag_ff        <= total_ff;
         end else begin
            rsp_flipped_ff    <= doflip;
            rsp_spin_after_ff <= me ^ doflip;
            rsp_nsum_ff       <= nsum;
            rsp_mag_ff        <= doflip ? total_next : total_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flipped       = rsp_flipped_ff;
   assign rsp_spin_after    = rsp_spin_after_ff;
   assign rsp_neighbour_sum = $signed(rsp_nsum_ff);
   assign rsp_magnetization = $signed(rsp_mag_ff);
   assign rsp_bad_site      = rsp_bad_site_ff;

endmodule

/* bench/tb_triangular_ising_metropolis_step.sv */
`timescale 1ns / 1ps

module tb_triangular_ising_metropolis_step;
   import tism_pkg::*;

   localparam int CELLS      = SIDE_MAX * SIDE_MAX;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic                     flipped;
      logic                     spin_after;
      logic signed [NSUM_W-1:0] neighbour_sum;
      logic signed [MAG_W-1:0]  magnetization;
      logic                     bad_site;
   } spin_result_type;

   class lattice_scoreboard;
      bit                      down_spin [CELLS];
      logic [SIDE_FIELD_W-1:0] side_reg;
      logic [DRAW_W-1:0]       thr_k2;
      logic [DRAW_W-1:0]       thr_k4;
      logic [DRAW_W-1:0]       thr_k6;
      int                      spin_sum;
      spin_result_type         awaited [$];
      int                      errors;

      function new();
         side_reg = SIDE_FIELD_W'(SIDE_MAX);
         thr_k2   = '0;
         thr_k4   = '0;
         thr_k6   = '0;
         errors   = 0;
         all_up();
      endfunction

      function int eff_side();
         if (side_reg < 2) return 2;
         if (side_reg > SIDE_MAX) return SIDE_MAX;
         return int'(side_reg);
      endfunction

      function void all_up();
         int s;
         s = eff_side();
         foreach (down_spin[i]) down_spin[i] = 1'b0;
         spin_sum = s * s;
      endfunction

      function int spin_at(int row, int col, int s);
         return down_spin[(row * s + col) % CELLS] ? -1 : 1;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] word);
         case (idx)
            CSR_SIDE: begin
               side_reg = word[SIDE_FIELD_W-1:0];
               all_up();
            end
            CSR_ACCEPT_K2: thr_k2 = word[DRAW_W-1:0];
            CSR_ACCEPT_K4: thr_k4 = word[DRAW_W-1:0];
            CSR_ACCEPT_K6: thr_k6 = word[DRAW_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_step(logic [SITE_W-1:0] site, logic [DRAW_W-1:0] draw);
         int              s;
         int              row;
         int              col;
         int              up_row;
         int              dn_row;
         int              lf_col;
         int              rt_col;
         int              nsum;
         int              me;
         int              k;
         bit              flip;
         spin_result_type e;
         s = eff_side();
         e = '0;
         if (int'(site) >= s * s) begin
            e.bad_site = 1'b1;
         end else begin
            row    = int'(site) / s;
            col    = int'(site) % s;
            up_row = (row + s - 1) % s;
            dn_row = (row + 1) % s;
            lf_col = (col + s - 1) % s;
            rt_col = (col + 1) % s;
            nsum = spin_at(row, lf_col, s) + spin_at(row, rt_col, s)
                 + spin_at(up_row, col, s) + spin_at(dn_row, col, s)
                 + spin_at(up_row, lf_col, s) + spin_at(dn_row, rt_col, s);
            me = down_spin[site] ? -1 : 1;
            k  = me * nsum;
            if (k <= 0)      flip = 1'b1;
            else if (k == 2) flip = draw < thr_k2;
            else if (k == 4) flip = draw < thr_k4;
            else             flip = draw < thr_k6;
            if (flip) begin
               down_spin[site] = ~down_spin[site];
               spin_sum += (me > 0) ? -2 : 2;
            end
            e.flipped       = flip;
            e.spin_after    = down_spin[site];
            e.neighbour_sum = NSUM_W'(nsum);
         end
         e.magnetization = MAG_W'(spin_sum);
         awaited.push_back(e);
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%0t ns: mismatch, %s", $realtime, what);
      endfunction

      function void cmp(string name, logic signed [31:0] want, logic signed [31:0] got);
         if (got !== want) flag($sformatf("%s expected %0d got %0d", name, want, got));
      endfunction

      function void match_result(spin_result_type got);
         spin_result_type want;
         if (awaited.size() == 0) begin
            flag("result beat with nothing outstanding");
            return;
         end
         want = awaited.pop_front();
         cmp("flipped", {31'd0, want.flipped}, {31'd0, got.flipped});
         cmp("spin_after", {31'd0, want.spin_after}, {31'd0, got.spin_after});
         cmp("neighbour_sum", want.neighbour_sum, got.neighbour_sum);
         cmp("magnetization", want.magnetization, got.magnetization);
         cmp("bad_site", {31'd0, want.bad_site}, {31'd0, got.bad_site});
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [SITE_W-1:0]        req_site;
   logic [DRAW_W-1:0]        req_random_draw;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_flipped;
   logic                     rsp_spin_after;
   logic signed [NSUM_W-1:0] rsp_neighbour_sum;
   logic signed [MAG_W-1:0]  rsp_magnetization;
   logic                     rsp_bad_site;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   lattice_scoreboard sb;
   int                tx_idle_pct;
   int                rx_idle_pct;
   bit                hold_req;
   int                quiet_cycles;

   triangular_ising_metropolis_step i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_site          (req_site),
      .req_random_draw   (req_random_draw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_flipped       (rsp_flipped),
      .rsp_spin_after    (rsp_spin_after),
      .rsp_neighbour_sum (rsp_neighbour_sum),
      .rsp_magnetization (rsp_magnetization),
      .rsp_bad_site      (rsp_bad_site),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                   || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_triangular_ising_metropolis_step: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int hold_left;
      spin_result_type got;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.flipped       = rsp_flipped;
            got.spin_after    = rsp_spin_after;
            got.neighbour_sum = rsp_neighbour_sum;
            got.magnetization = rsp_magnetization;
            got.bad_site      = rsp_bad_site;
            sb.match_result(got);
         end
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   task automatic send_beat(logic [SITE_W-1:0] site, logic [DRAW_W-1:0] draw);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_site        <= site;
      req_random_draw <= draw;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_step(site, draw);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] word);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.configure(idx, word);
   endtask

   task automatic program_regs(bit with_side, logic [CSR_DATA_W-1:0] side_word,
                               logic [CSR_DATA_W-1:0] k2, logic [CSR_DATA_W-1:0] k4,
                               logic [CSR_DATA_W-1:0] k6);
      if (with_side) write_reg(CSR_SIDE, side_word);
      write_reg(CSR_ACCEPT_K2, k2);
      write_reg(CSR_ACCEPT_K4, k4);
      write_reg(CSR_ACCEPT_K6, k6);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SITE_W-1:0] pick_site(int s);
      int cells;
      cells = s * s;
      case ($urandom_range(15))
         0: return SITE_W'($urandom_range(CELLS - 1));
         1: return SITE_W'(cells - 1);
         2: return (cells < CELLS) ? SITE_W'(cells) : SITE_W'(0);
         default: return SITE_W'($urandom_range(cells - 1));
      endcase
   endfunction

   function automatic logic [DRAW_W-1:0] pick_draw();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return DRAW_W'($urandom_range(65535));
      endcase
   endfunction

   task automatic run_random(int count);
      repeat (count) send_beat(pick_site(sb.eff_side()), pick_draw());
      drain();
   endtask

   function automatic logic [CSR_DATA_W-1:0] any_thr();
      return CSR_DATA_W'($urandom_range(65535));
   endfunction

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_site        = '0;
      req_random_draw = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_SIDE;
      csr_data        = '0;
      tx_idle_pct     = 21;
      rx_idle_pct     = 51;
      hold_req        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero thresholds out of reset: nothing may flip on a fully aligned lattice
      send_beat(12'd0, 16'h0000);
      send_beat(12'd4095, 16'hFFFF);
      send_beat(12'd4032, 16'h8000);
      send_beat(12'd63, 16'h0001);
      drain();

      program_regs(1'b1, 16'hFF83, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(12'd0, 16'h0000);
      send_beat(12'd1, 16'hFFFF);
      send_beat(12'd9, 16'h0000);
      send_beat(12'd4095, 16'h0000);
      send_beat(12'd4, 16'h0000);
      send_beat(12'd8, 16'h7FFF);
      send_beat(12'd4, 16'hFFFF);
      drain();

      program_regs(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      send_beat(12'd0, 16'h0000);
      send_beat(12'd3, 16'h0000);
      send_beat(12'd4, 16'h0000);
      send_beat(12'd2, 16'hFFFE);
      drain();

      program_regs(1'b1, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
      send_beat(12'd1, 16'h0000);
      send_beat(12'd2, 16'h0000);
      drain();

      program_regs(1'b1, 16'h003F, 16'h8000, 16'h8000, 16'h8000);
      send_beat(12'd3969, 16'h0000);
      send_beat(12'd3968, 16'h0000);
      drain();

      program_regs(1'b1, 16'hFFC1, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_beat(12'd2080, 16'h1234);
      send_beat(12'd4095, 16'h0000);
      drain();

      // long receiver hold-off while the sender keeps offering items
      program_regs(1'b1, 16'd5, 16'h8000, 16'h4000, 16'h1000);
      hold_req = 1'b1;
      run_random(200);
      program_regs(1'b1, 16'd64, any_thr(), any_thr(), any_thr());
      run_random(150);
      program_regs(1'b0, 16'd0, any_thr(), any_thr(), any_thr());
      run_random(150);

      tx_idle_pct = 51;
      rx_idle_pct = 21;
      program_regs(1'b1, 16'd2, any_thr(), any_thr(), any_thr());
      run_random(150);
      program_regs(1'b1, {9'($urandom_range(511)), 7'h7F}, any_thr(), any_thr(),
                   any_thr());
      run_random(150);
      program_regs(1'b1, 16'd7, 16'hFFFF, 16'h0000, 16'hFFFF);
      run_random(150);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      program_regs(1'b1, 16'd63, any_thr(), any_thr(), any_thr());
      run_random(200);
      program_regs(1'b1, 16'd4, any_thr(), any_thr(), any_thr());
      run_random(250);
      program_regs(1'b0, 16'd0, 16'h0000, 16'h0000, 16'h0000);
      run_random(100);

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_triangular_ising_metropolis_step: done, clean");
      end else begin
         $display("tb_triangular_ising_metropolis_step: done, errors");
      end
      $finish;
   end

endmodule
